[rtl/core/csxxh_pkg.sv]
// ----------------------------------------------------------------------------
// csxxh_pkg: shared types and constants of the call-stack XXH64 hasher
// Word layouts of both channels, XXH64 primes, register indexes and helpers.
// ----------------------------------------------------------------------------
package csxxh_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned WCNT_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Saturation point of the reported frame count
  localparam int unsigned MAX_FRAMES = 64;

  // XXH64 primes
  localparam logic [63:0] PR1 = 64'h9E37_79B1_85EB_CA87;
  localparam logic [63:0] PR2 = 64'hC2B2_AE3D_27D4_EB4F;
  localparam logic [63:0] PR3 = 64'h1656_67B1_9E37_79F9;
  localparam logic [63:0] PR4 = 64'h85EB_CA77_C2B2_AE63;
  localparam logic [63:0] PR5 = 64'h27D4_EB2F_1656_67C5;
  localparam logic [63:0] PR12 = PR1 + PR2;

  localparam logic [63:0] SEED_RESET = 64'h9E37_79B9_7F4A_7C15;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEED      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_LSB = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP      = 2'd2;

  typedef struct packed {
    logic [WORD_W-1:0] frame_addr;
    logic              last_frame;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] stack_hash;
    logic [CNT_W-1:0]  hashed_count;
    logic              too_many_frames;
  } out_word_t;

  // Rotate left by a constant amount (1..63)
  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

endpackage

[rtl/core/csxxh_mul.sv]
// ----------------------------------------------------------------------------
// csxxh_mul: iterative 64x64 multiplier, low 64 bits of the product
// One 32x32 multiplier is used over three steps; the three partial products
// that reach the low word are summed into a product register.
// ----------------------------------------------------------------------------
module csxxh_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] prod
);
  import csxxh_pkg::*;

  localparam logic [1:0] STEP_IDLE = 2'd0;
  localparam logic [1:0] STEP_LL   = 2'd1;
  localparam logic [1:0] STEP_LH   = 2'd2;
  localparam logic [1:0] STEP_HL   = 2'd3;

  logic [1:0]  step_r;
  logic        done_r;
  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] acc_r;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] pp;

  // Operand select for the shared multiplier
  always_comb begin
    case (step_r)
      STEP_LH: begin
        op_a = a_r[31:0];
        op_b = b_r[63:32];
      end
      STEP_HL: begin
        op_a = a_r[63:32];
        op_b = b_r[31:0];
      end
      default: begin
        op_a = a_r[31:0];
        op_b = b_r[31:0];
      end
    endcase
  end

  assign pp = op_a * op_b;

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (step_r)
        STEP_IDLE: if (start) step_r <= STEP_LL;
        STEP_LL:   step_r <= STEP_LH;
        STEP_LH:   step_r <= STEP_HL;
        STEP_HL: begin
          step_r <= STEP_IDLE;
          done_r <= 1'b1;
        end
        default:   step_r <= STEP_IDLE;
      endcase
    end
  end

  // Operand capture and partial-product accumulation
  always_ff @(posedge clk) begin
    if (step_r == STEP_IDLE && start) begin
      a_r <= a;
      b_r <= b;
    end
    case (step_r)
      STEP_LL: acc_r <= pp;
      STEP_LH, STEP_HL: acc_r[63:32] <= acc_r[63:32] + pp[31:0];
      default: acc_r <= acc_r;
    endcase
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

[rtl/core/call_stack_xxh64_hasher.sv]
// ----------------------------------------------------------------------------
// call_stack_xxh64_hasher: XXH64 digest of a call stack, one word per frame
// Small sequencer around one shared iterative multiplier; lanes, stripe
// buffer and stack bookkeeping live here, with the config and output regs.
// ----------------------------------------------------------------------------
// A frame in stripe slots 0..2 is buffered without a lane round; a stripe-closing
//   frame runs four lane rounds (8 products on the shared 32x32 unit).
// A last frame adds stack end, merge and length (both only if a stripe was
//   hashed), up to 3 tail rounds, avalanche and output, then returns to idle.
// All products share the single multiplier; in_ready is low outside idle.
// Reset (synchronous, rst_n low) restores register defaults, clears stack state.
module call_stack_xxh64_hasher (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  csxxh_pkg::in_word_t         in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output csxxh_pkg::out_word_t        out_data,
  input  logic                        cfg_we,
  input  logic [csxxh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                 cfg_data
);
  import csxxh_pkg::*;

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LR_M1 = 4'd1;
  localparam logic [3:0] ST_LR_M2 = 4'd2;
  localparam logic [3:0] ST_MIX   = 4'd3;
  localparam logic [3:0] ST_FIN   = 4'd4;
  localparam logic [3:0] ST_LEN   = 4'd5;
  localparam logic [3:0] ST_TAIL  = 4'd6;
  localparam logic [3:0] ST_AV1   = 4'd7;
  localparam logic [3:0] ST_AV2   = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  // Round modes
  localparam logic [1:0] MD_STRIPE = 2'd0;
  localparam logic [1:0] MD_MERGE  = 2'd1;
  localparam logic [1:0] MD_TAIL   = 2'd2;

  // Configuration
  logic [63:0] seed_r, seed_nxt;
  logic        clr_r, clr_nxt;
  logic        skip_r, skip_nxt;

  // Control
  logic [3:0]        state_r, state_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [1:0]        li_r, li_nxt;
  logic              go_r, go_nxt;
  logic              first_pend_r, first_pend_nxt;
  logic [WCNT_W-1:0] wcnt_r, wcnt_nxt;
  logic              stripe_r, stripe_nxt;
  logic              over_r, over_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Datapath
  logic [63:0] lane_r [4];
  logic [63:0] lane_nxt [4];
  logic [63:0] buf_r [3];
  logic [63:0] buf_nxt [3];
  logic [63:0] addr_r, addr_nxt;
  logic [63:0] t_r, t_nxt;
  logic [63:0] h_r, h_nxt;
  logic        last_r, last_nxt;
  out_word_t   out_data_r, out_data_nxt;

  // Shared multiplier
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic [63:0] mul_p;
  logic        mul_done;

  logic [63:0]       addr_in;
  logic              stk_start;
  logic [WCNT_W-1:0] wcnt_inc;
  logic [63:0]       word_sel;
  logic [63:0]       lane_sel;
  logic [63:0]       round_acc;
  logic [63:0]       len8;
  logic [63:0]       merge_sum;
  logic [CNT_W-1:0]  cnt_out;

  csxxh_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Common decode
  assign addr_in   = in_data.frame_addr & ~{63'd0, clr_r};
  assign stk_start = (wcnt_r == '0) && !stripe_r;
  assign wcnt_inc  = wcnt_r + 1'b1;
  assign lane_sel  = lane_r[li_r];
  assign round_acc = (mode_r == MD_STRIPE) ? lane_sel : 64'd0;
  assign len8      = {{(64 - WCNT_W - 3){1'b0}}, wcnt_r, 3'b000};
  assign merge_sum = rotl64(lane_r[0], 1) + rotl64(lane_r[1], 7)
                   + rotl64(lane_r[2], 12) + rotl64(lane_r[3], 18);
  assign cnt_out   = over_r ? CNT_W'(MAX_FRAMES) : wcnt_r[CNT_W-1:0];

  // Word for a stripe or tail round: buffer slot, or the stripe-closing frame
  always_comb begin
    case (li_r)
      2'd0:    word_sel = buf_r[0];
      2'd1:    word_sel = buf_r[1];
      2'd2:    word_sel = buf_r[2];
      default: word_sel = addr_r;
    endcase
  end

  // Sequencer and next-state datapath
  always_comb begin
    seed_nxt       = seed_r;
    clr_nxt        = clr_r;
    skip_nxt       = skip_r;
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    li_nxt         = li_r;
    go_nxt         = 1'b0;
    first_pend_nxt = first_pend_r;
    wcnt_nxt       = wcnt_r;
    stripe_nxt     = stripe_r;
    over_nxt       = over_r;
    out_valid_nxt  = out_valid_r;
    lane_nxt       = lane_r;
    buf_nxt        = buf_r;
    addr_nxt       = addr_r;
    t_nxt          = t_r;
    h_nxt          = h_r;
    last_nxt       = last_r;
    out_data_nxt   = out_data_r;
    mul_a          = h_r;
    mul_b          = PR1;

    // Register writes
    if (cfg_we) begin
      case (cfg_index)
        REG_SEED:      seed_nxt = cfg_data;
        REG_CLEAR_LSB: clr_nxt  = cfg_data[0];
        REG_SKIP:      skip_nxt = cfg_data[0];
        default: ;
      endcase
    end

    // Output word taken
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (stk_start && !first_pend_r && skip_r && !in_data.last_frame) begin
            // first frame of a longer stack is dropped
            first_pend_nxt = 1'b1;
          end else begin
            first_pend_nxt = 1'b0;
            last_nxt       = in_data.last_frame;
            wcnt_nxt       = wcnt_inc;
            if (wcnt_inc > WCNT_W'(MAX_FRAMES)) over_nxt = 1'b1;
            if (stk_start) begin
              lane_nxt[0] = seed_r + PR12;
              lane_nxt[1] = seed_r + PR2;
              lane_nxt[2] = seed_r;
              lane_nxt[3] = seed_r - PR1;
            end
            if (wcnt_r[1:0] != 2'd3) begin
              buf_nxt[wcnt_r[1:0]] = addr_in;
              if (in_data.last_frame) state_nxt = ST_FIN;
            end else begin
              addr_nxt   = addr_in;
              stripe_nxt = 1'b1;
              li_nxt     = 2'd0;
              mode_nxt   = MD_STRIPE;
              state_nxt  = ST_LR_M1;
              go_nxt     = 1'b1;
            end
          end
        end
      end

      // acc + w * PR2, rotated
      ST_LR_M1: begin
        mul_a = (mode_r == MD_MERGE) ? lane_sel : word_sel;
        mul_b = PR2;
        if (mul_done) begin
          t_nxt     = rotl64(round_acc + mul_p, 31);
          state_nxt = ST_LR_M2;
          go_nxt    = 1'b1;
        end
      end

      // ... * PR1, then route by mode
      ST_LR_M2: begin
        mul_a = t_r;
        mul_b = PR1;
        if (mul_done) begin
          case (mode_r)
            MD_STRIPE: begin
              lane_nxt[li_r] = mul_p;
              if (li_r == 2'd3) begin
                li_nxt    = 2'd0;
                state_nxt = last_r ? ST_FIN : ST_IDLE;
              end else begin
                li_nxt    = li_r + 1'b1;
                state_nxt = ST_LR_M1;
                go_nxt    = 1'b1;
              end
            end
            MD_MERGE: begin
              h_nxt     = h_r ^ mul_p;
              state_nxt = ST_MIX;
              go_nxt    = 1'b1;
            end
            MD_TAIL: begin
              h_nxt     = rotl64(h_r ^ mul_p, 27);
              state_nxt = ST_MIX;
              go_nxt    = 1'b1;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      // h * PR1 + PR4
      ST_MIX: begin
        mul_a = h_r;
        mul_b = PR1;
        if (mul_done) begin
          h_nxt = mul_p + PR4;
          if (mode_r == MD_MERGE) begin
            if (li_r == 2'd3) begin
              li_nxt    = 2'd0;
              state_nxt = ST_LEN;
            end else begin
              li_nxt    = li_r + 1'b1;
              state_nxt = ST_LR_M1;
              go_nxt    = 1'b1;
            end
          end else begin
            li_nxt    = li_r + 1'b1;
            state_nxt = ST_TAIL;
          end
        end
      end

      // Stack end: lane fold, or short-input start value
      ST_FIN: begin
        li_nxt = 2'd0;
        if (stripe_r) begin
          h_nxt     = merge_sum;
          mode_nxt  = MD_MERGE;
          state_nxt = ST_LR_M1;
          go_nxt    = 1'b1;
        end else begin
          h_nxt     = seed_r + PR5 + len8;
          mode_nxt  = MD_TAIL;
          state_nxt = ST_TAIL;
        end
      end

      ST_LEN: begin
        h_nxt     = h_r + len8;
        mode_nxt  = MD_TAIL;
        state_nxt = ST_TAIL;
      end

      // Leftover 8-byte words, then start the avalanche
      ST_TAIL: begin
        if (li_r < wcnt_r[1:0]) begin
          state_nxt = ST_LR_M1;
          go_nxt    = 1'b1;
        end else begin
          h_nxt     = h_r ^ (h_r >> 33);
          state_nxt = ST_AV1;
          go_nxt    = 1'b1;
        end
      end

      ST_AV1: begin
        mul_a = h_r;
        mul_b = PR2;
        if (mul_done) begin
          h_nxt     = mul_p ^ (mul_p >> 29);
          state_nxt = ST_AV2;
          go_nxt    = 1'b1;
        end
      end

      ST_AV2: begin
        mul_a = h_r;
        mul_b = PR3;
        if (mul_done) begin
          h_nxt     = mul_p ^ (mul_p >> 32);
          state_nxt = ST_OUT;
        end
      end

      // Hand the digest to the output register once it is free
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.stack_hash      = h_r;
          out_data_nxt.hashed_count    = cnt_out;
          out_data_nxt.too_many_frames = over_r;
          out_valid_nxt  = 1'b1;
          wcnt_nxt       = '0;
          stripe_nxt     = 1'b0;
          over_nxt       = 1'b0;
          first_pend_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r       <= SEED_RESET;
      clr_r        <= 1'b1;
      skip_r       <= 1'b1;
      state_r      <= ST_IDLE;
      mode_r       <= MD_STRIPE;
      li_r         <= 2'd0;
      go_r         <= 1'b0;
      first_pend_r <= 1'b0;
      wcnt_r       <= '0;
      stripe_r     <= 1'b0;
      over_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      seed_r       <= seed_nxt;
      clr_r        <= clr_nxt;
      skip_r       <= skip_nxt;
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      li_r         <= li_nxt;
      go_r         <= go_nxt;
      first_pend_r <= first_pend_nxt;
      wcnt_r       <= wcnt_nxt;
      stripe_r     <= stripe_nxt;
      over_r       <= over_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lane_r     <= lane_nxt;
    buf_r      <= buf_nxt;
    addr_r     <= addr_nxt;
    t_r        <= t_nxt;
    h_r        <= h_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
